### rtl/core/spsq_pkg.sv
// ----------------------------------------------------------------------------
// spsq_pkg
// Shared types and codes for the stable priority service queue.
// ----------------------------------------------------------------------------
`default_nettype none

package spsq_pkg;

  localparam int SPSQ_CAPACITY = 32;

  localparam int ID_W   = 8;
  localparam int PRIO_W = 4;
  localparam int TIME_W = 8;
  localparam int ACC_W  = 16;
  localparam int OCC_W  = 6;

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_SERVE  = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_SERVED   = 2'd1,
    ST_FULL     = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
    logic [TIME_W-1:0] svc_time;
  } entry_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic   insert;
    logic   pop;
    entry_t data;
  } cell_cmd_t;

endpackage : spsq_pkg

`default_nettype wire

### rtl/core/spsq_cell.sv
// ----------------------------------------------------------------------------
// spsq_cell
// One slot of the sorted chain: holds an entry, shifts right on insert
// below it, shifts left on pop.
// ----------------------------------------------------------------------------
`default_nettype none

module spsq_cell (
  input  wire                     clk,
  input  spsq_pkg::cell_cmd_t     cmd,
  input  wire                     occupied,
  input  wire                     left_keep,
  input  spsq_pkg::entry_t        left_entry,
  input  spsq_pkg::entry_t        right_entry,
  output logic                    keep,
  output spsq_pkg::entry_t        entry
);
  import spsq_pkg::*;

  entry_t entry_next;

  // an equal priority stays ahead of the new one, so ties keep arrival order
  assign keep = occupied && (entry.prio >= cmd.data.prio);

  always_comb begin
    entry_next = entry;
    if (cmd.pop) begin
      entry_next = right_entry;
    end else if (cmd.insert && !keep) begin
      entry_next = left_keep ? cmd.data : left_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule : spsq_cell

`default_nettype wire

### rtl/core/stable_priority_service_queue_unit.sv
// ----------------------------------------------------------------------------
// stable_priority_service_queue_unit
// Priority queue kept as a chain of cells sorted by priority, oldest first
// among equal priorities; serve pops the head cell.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                                 | tuser
//  s_*     | in  | id, priority, time                    | kind
//  m_*     | out | id, priority, time, time_before, occ  | status
//
//  one request per cycle: an insert or a pop is one shift of the cell chain,
//  the result appears in the output register the cycle after the request
//  is taken. s_tready drops only while a result waits unread.
//  reset clears the entry count, the time total and the output valid; cell
//  contents need no clearing since only cells below the count are used.
`default_nettype none

module stable_priority_service_queue_unit #(
  parameter int CAPACITY = spsq_pkg::SPSQ_CAPACITY
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [23:0] s_tdata,   // id[7:0], priority[11:8], time[19:12], zero pad
  input  wire  [0:0]  s_tuser,   // kind[0]
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [47:0] m_tdata,   // id[7:0], priority[11:8], time[19:12],
                                 // time_before[35:20], occupancy[41:36], zero pad
  output logic [1:0]  m_tuser    // status[1:0]
);
  import spsq_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0] count, count_next;
  logic [ACC_W-1:0] acc, acc_next;
  logic             in_accept, is_serve, full, empty;
  cell_cmd_t        cmd;
  entry_t           cell_entry [CAPACITY];
  logic             cell_keep  [CAPACITY];
  entry_t           head;
  logic [ACC_W:0]   sum;

  status_t          res_status;
  entry_t           res_entry;
  logic [ACC_W-1:0] res_before;

  assign s_tready  = !m_tvalid || m_tready;
  assign in_accept = s_tvalid && s_tready;
  assign is_serve  = (s_tuser[0] == KIND_SERVE);
  assign full      = (count == CNT_W'(CAPACITY));
  assign empty     = (count == '0);
  assign head      = cell_entry[0];

  assign cmd.insert        = in_accept && !is_serve && !full;
  assign cmd.pop           = in_accept && is_serve && !empty;
  assign cmd.data.id       = s_tdata[7:0];
  assign cmd.data.prio     = s_tdata[11:8];
  assign cmd.data.svc_time = s_tdata[19:12];

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      logic   occ;
      logic   lkeep;
      entry_t lentry;
      entry_t rentry;
      assign occ = (CNT_W'(i) < count);
      if (i == 0) begin : g_first
        assign lkeep  = 1'b1;
        assign lentry = cmd.data;
      end else begin : g_mid
        assign lkeep  = cell_keep[i-1];
        assign lentry = cell_entry[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
        assign rentry = cell_entry[i];
      end else begin : g_inner
        assign rentry = cell_entry[i+1];
      end
      spsq_cell u_cell (
        .clk         (clk),
        .cmd         (cmd),
        .occupied    (occ),
        .left_keep   (lkeep),
        .left_entry  (lentry),
        .right_entry (rentry),
        .keep        (cell_keep[i]),
        .entry       (cell_entry[i])
      );
    end
  endgenerate

  assign sum = {1'b0, acc} + (ACC_W+1)'(head.svc_time);

  always_comb begin
    count_next = count;
    acc_next   = acc;
    if (cmd.insert) begin
      count_next = count + CNT_W'(1);
    end else if (cmd.pop) begin
      count_next = count - CNT_W'(1);
      acc_next   = sum[ACC_W] ? {ACC_W{1'b1}} : sum[ACC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      acc      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      count <= count_next;
      acc   <= acc_next;
      if (in_accept) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      res_entry  <= '0;
      res_before <= '0;
      if (!is_serve) begin
        res_status <= full ? ST_FULL : ST_INSERTED;
      end else if (empty) begin
        res_status <= ST_EMPTY;
      end else begin
        res_status <= ST_SERVED;
        res_entry  <= head;
        res_before <= acc;
      end
    end
  end

  // occupancy reflects the count after the request, masked to the field
  logic [OCC_W-1:0] occ_out;
  assign occ_out = OCC_W'(count);

  assign m_tuser = res_status;
  assign m_tdata = {6'd0, occ_out, res_before, res_entry.svc_time,
                    res_entry.prio, res_entry.id};

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_head_sorted: assert property (@(posedge clk) disable iff (rst)
    (count >= CNT_W'(2)) |-> (cell_entry[0].prio >= cell_entry[1].prio))
    else $error("head cell not the highest priority");

  a_full_reject: assert property (@(posedge clk) disable iff (rst)
    (in_accept && !is_serve && full) |=>
      (m_tuser == ST_FULL) && (count == CNT_W'(CAPACITY)))
    else $error("insert on full store not rejected");

  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    (in_accept && is_serve && !empty) |=> (count == $past(count) - CNT_W'(1)))
    else $error("serve did not remove one entry");

  a_acc_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (acc >= $past(acc)))
    else $error("accumulated time decreased");
`endif

endmodule : stable_priority_service_queue_unit

`default_nettype wire

### tb/stable_priority_service_queue_unit_tb.sv
// ----------------------------------------------------------------------------
// stable_priority_service_queue_unit_tb
// Self-checking bench for the priority service queue: a directed table of
// requests, then random fill, drain and mixed rounds. Each result is checked
// field by field against an in-bench model of the queue or a pinned table
// outcome. Both sides of the stream interface stall at random.
// ----------------------------------------------------------------------------
module stable_priority_service_queue_unit_tb;
  import spsq_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PLAN_LEN    = 23;
  localparam int MIN_ITEMS   = 500;

  typedef struct packed {
    status_t           status;
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
    logic [TIME_W-1:0] svc;
    logic [ACC_W-1:0]  prior_total;
    logic [OCC_W-1:0]  occ;
  } outcome_t;

  typedef struct packed {
    kind_t    kind;
    entry_t   ent;
    logic     pin;   // outcome typed in below instead of taken from the model
    outcome_t want;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;   // id[7:0], priority[11:8], time[19:12], zero pad
  logic [0:0]  s_tuser = '0;   // kind[0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;        // id[7:0], priority[11:8], time[19:12],
                               // time_before[35:20], occupancy[41:36], zero pad
  logic [1:0]  m_tuser;        // status[1:0]

  stable_priority_service_queue_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // queue model state
  entry_t          waiting_q[$];
  logic [ACC_W-1:0] served_total = '0;
  outcome_t        outcome_q[$];

  plan_row_t plan [PLAN_LEN];

  bit quiet = 1'b0;
  int sent_cnt = 0;
  int insert_cnt = 0;
  int serve_cnt = 0;
  int full_cnt = 0;
  int empty_cnt = 0;
  int sat_cnt = 0;
  int checked_cnt = 0;
  int mismatch_cnt = 0;
  int cycle_cnt = 0;
  int stall_left = 0;

  // next outcome of the queue for one request, updates the model state
  function automatic outcome_t apply_request(kind_t kind, entry_t ent);
    outcome_t    o;
    int          best;
    int unsigned sum;
    o = '0;
    if (kind == KIND_INSERT) begin
      if (waiting_q.size() >= SPSQ_CAPACITY) begin
        o.status = ST_FULL;
        full_cnt++;
      end else begin
        waiting_q.push_back(ent);
        o.status = ST_INSERTED;
        insert_cnt++;
      end
    end else if (waiting_q.size() == 0) begin
      o.status = ST_EMPTY;
      empty_cnt++;
    end else begin
      best = 0;
      // strict compare keeps the oldest of equal priorities
      for (int i = 1; i < waiting_q.size(); i++) begin
        if (waiting_q[i].prio > waiting_q[best].prio) best = i;
      end
      o.status      = ST_SERVED;
      o.id          = waiting_q[best].id;
      o.prio        = waiting_q[best].prio;
      o.svc         = waiting_q[best].svc_time;
      o.prior_total = served_total;
      sum = served_total + waiting_q[best].svc_time;
      served_total = (sum > 16'hFFFF) ? 16'hFFFF : sum[ACC_W-1:0];
      waiting_q.delete(best);
      serve_cnt++;
      if (o.prior_total == 16'hFFFF) sat_cnt++;
    end
    o.occ = OCC_W'(waiting_q.size());
    return o;
  endfunction

  function automatic entry_t rand_entry();
    entry_t e;
    e.id = ID_W'($urandom_range(0, 255));
    // half the priorities crowd a narrow band so ties are common
    e.prio = $urandom_range(0, 1) ? PRIO_W'($urandom_range(0, 15))
                                  : PRIO_W'($urandom_range(6, 8));
    // long service times push the total up toward saturation
    e.svc_time = ($urandom_range(0, 3) != 0) ? TIME_W'($urandom_range(200, 255))
                                             : TIME_W'($urandom_range(0, 255));
    return e;
  endfunction

  task automatic send_request(kind_t kind, entry_t ent, logic pin, outcome_t want);
    outcome_t o;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    o = apply_request(kind, ent);
    outcome_q.push_back(pin ? want : o);
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, ent.svc_time, ent.prio, ent.id};
    s_tuser  <= kind;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent_cnt++;
  endtask

  task automatic note_mismatch(string field, logic [15:0] want, logic [15:0] got);
    mismatch_cnt++;
    if (mismatch_cnt <= 10)
      $display("mismatch on result %0d, %s: expected %h, got %h",
               checked_cnt, field, want, got);
  endtask

  // result side: random stall bursts, none in the closing stretch
  always @(posedge clk) begin
    if (stall_left > 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      m_tready   <= 1'b0;
      stall_left <= $urandom_range(1, 6) - 1;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    outcome_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (outcome_q.size() == 0) begin
        note_mismatch("unexpected result", '0, {m_tuser, m_tdata[13:0]});
      end else begin
        want = outcome_q.pop_front();
        if (m_tuser !== want.status)      note_mismatch("status", want.status, m_tuser);
        if (m_tdata[7:0] !== want.id)     note_mismatch("served_id", want.id, m_tdata[7:0]);
        if (m_tdata[11:8] !== want.prio)  note_mismatch("served_priority", want.prio,
                                                        m_tdata[11:8]);
        if (m_tdata[19:12] !== want.svc)  note_mismatch("served_time", want.svc,
                                                        m_tdata[19:12]);
        if (m_tdata[35:20] !== want.prior_total)
          note_mismatch("time_before", want.prior_total, m_tdata[35:20]);
        if (m_tdata[41:36] !== want.occ)  note_mismatch("occupancy", want.occ, m_tdata[41:36]);
        if (m_tdata[47:42] !== 6'b0)      note_mismatch("pad", '0, m_tdata[47:42]);
      end
      checked_cnt++;
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout with %0d results outstanding", outcome_q.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int     round_sel;
    int     n;
    entry_t ent;

    plan = '{
      '{KIND_SERVE,  '{8'h00, 4'h0, 8'h00}, 1'b1, '{ST_EMPTY,    8'h00, 4'h0, 8'h00, 16'h0, 6'd0}},
      '{KIND_INSERT, '{8'h00, 4'h0, 8'h00}, 1'b1, '{ST_INSERTED, 8'h00, 4'h0, 8'h00, 16'h0, 6'd1}},
      '{KIND_INSERT, '{8'hFF, 4'hF, 8'hFF}, 1'b1, '{ST_INSERTED, 8'h00, 4'h0, 8'h00, 16'h0, 6'd2}},
      '{KIND_INSERT, '{8'hA5, 4'hF, 8'h5A}, 1'b0, '0},
      '{KIND_INSERT, '{8'h5A, 4'h7, 8'hA5}, 1'b0, '0},
      '{KIND_SERVE,  '{8'h00, 4'h0, 8'h00}, 1'b1, '{ST_SERVED,   8'hFF, 4'hF, 8'hFF, 16'h0, 6'd3}},
      '{KIND_SERVE,  '{8'hFF, 4'hF, 8'hFF}, 1'b0, '0},
      '{KIND_INSERT, '{8'h11, 4'h7, 8'h01}, 1'b0, '0},
      '{KIND_SERVE,  '{8'h00, 4'h0, 8'h00}, 1'b0, '0},
      '{KIND_SERVE,  '{8'h33, 4'h9, 8'hC0}, 1'b0, '0},
      '{KIND_SERVE,  '{8'h00, 4'h0, 8'h00}, 1'b0, '0},
      '{KIND_SERVE,  '{8'hFF, 4'hF, 8'hFF}, 1'b1, '{ST_EMPTY,    8'h00, 4'h0, 8'h00, 16'h0, 6'd0}},
      '{KIND_INSERT, '{8'h3C, 4'h0, 8'h80}, 1'b0, '0},
      '{KIND_INSERT, '{8'hC3, 4'h8, 8'h7F}, 1'b0, '0},
      '{KIND_INSERT, '{8'h0F, 4'h3, 8'hF0}, 1'b0, '0},
      '{KIND_INSERT, '{8'hF0, 4'h8, 8'h0F}, 1'b0, '0},
      '{KIND_INSERT, '{8'h81, 4'h0, 8'hFF}, 1'b0, '0},
      '{KIND_SERVE,  '{8'h00, 4'h0, 8'h00}, 1'b0, '0},
      '{KIND_SERVE,  '{8'h00, 4'h0, 8'h00}, 1'b0, '0},
      '{KIND_SERVE,  '{8'h00, 4'h0, 8'h00}, 1'b0, '0},
      '{KIND_SERVE,  '{8'h00, 4'h0, 8'h00}, 1'b0, '0},
      '{KIND_SERVE,  '{8'h00, 4'h0, 8'h00}, 1'b0, '0},
      '{KIND_SERVE,  '{8'h00, 4'h0, 8'h00}, 1'b1, '{ST_EMPTY,    8'h00, 4'h0, 8'h00, 16'h0, 6'd0}}
    };

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < PLAN_LEN; r++)
      send_request(plan[r].kind, plan[r].ent, plan[r].pin, plan[r].want);

    // random rounds, the closing stretch runs with no idling
    while (sent_cnt < MIN_ITEMS) begin
      quiet = (sent_cnt >= MIN_ITEMS - 60);
      round_sel = $urandom_range(0, 3);
      case (round_sel)
        0: begin
          // fill to capacity, then knock on the full store
          while (waiting_q.size() < SPSQ_CAPACITY)
            send_request(KIND_INSERT, rand_entry(), 1'b0, '0);
          repeat ($urandom_range(1, 3)) send_request(KIND_INSERT, rand_entry(), 1'b0, '0);
        end
        1: begin
          // drain completely, then serve on empty
          while (waiting_q.size() > 0)
            send_request(KIND_SERVE, rand_entry(), 1'b0, '0);
          repeat ($urandom_range(1, 2)) send_request(KIND_SERVE, rand_entry(), 1'b0, '0);
        end
        default: begin
          n = $urandom_range(8, 30);
          repeat (n) begin
            ent = rand_entry();
            send_request($urandom_range(0, 1) ? KIND_SERVE : KIND_INSERT, ent, 1'b0, '0);
          end
        end
      endcase
    end

    s_tvalid <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("sent %0d requests: %0d inserts, %0d serves, %0d full rejects, %0d empty serves",
             sent_cnt, insert_cnt, serve_cnt, full_cnt, empty_cnt);
    $display("%0d results checked, %0d serves with the time total saturated, %0d mismatches",
             checked_cnt, sat_cnt, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### stable_priority_service_queue_unit.f
rtl/core/spsq_pkg.sv
rtl/core/spsq_cell.sv
rtl/core/stable_priority_service_queue_unit.sv
tb/stable_priority_service_queue_unit_tb.sv
